// File: hdl/brlw_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the bounded-range longest window block.
// No dependencies.
package brlw_pkg;

  localparam int unsigned DEPTH_DEF = 1024;
  localparam int unsigned SAMPLE_W  = 32;
  localparam int unsigned LIMIT_W   = 32;
  localparam int unsigned LEN_W     = 11;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       restart;
  } brlw_in_t;

  typedef struct packed {
    logic [LEN_W-1:0] window_length;
    logic [LEN_W-1:0] best_length;
    logic             window_capped;
  } brlw_out_t;

  typedef enum logic [2:0] {
    DQ_NONE,
    DQ_CLEAR,
    DQ_POP_FRONT,
    DQ_POP_BACK,
    DQ_PUSH
  } dq_op_e;

  typedef struct packed {
    logic start;
    logic cap;
    logic trim;
    logic push;
    logic shrink;
    logic finish;
  } brlw_cmd_t;

  typedef struct packed {
    logic cap_need;
    logic trim_need;
    logic pop_need;
    logic over_limit;
  } brlw_stat_t;

endpackage

// File: hdl/bounded_range_longest_window.sv
`timescale 1ns / 1ps
// Top level of the bounded-range longest window block: controller plus datapath.
// Uses brlw_pkg, brlw_ctrl, brlw_datapath (which holds two brlw_deque).
//
//   channel  direction  handshake               payload
//   in       input      in_valid_i/in_ready_o   brlw_in_t  {sample, restart}
//   out      output     out_valid_o/out_ready_i brlw_out_t {window_length, best_length,
//                                                           window_capped}
//   cfg      input      cfg_valid_i/cfg_ready_o range_limit, 32 bits
//
// An item runs through the controller's phases from accept to next accept: a cap check,
// stale front pops when the window is capped, back pops (both deques pop together) and
// the push, then stale front pops and left-edge steps, and a done phase.
// Reset empties both deques through their counters; storage is not cleared.
// A finished result waits in the output register while the next item is taken;
// the controller holds in its last phase only while a previous item is unread.
module bounded_range_longest_window import brlw_pkg::*; #(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  brlw_in_t           in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output brlw_out_t          out_data_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [LIMIT_W-1:0] cfg_data_i
);

  brlw_cmd_t  cmd;
  brlw_stat_t stat;

  assign cfg_ready_o = 1'b1;

  brlw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  brlw_datapath #(.DEPTH(DEPTH)) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .in_data_i  (in_data_i),
    .cfg_we_i   (cfg_valid_i),
    .cfg_data_i (cfg_data_i),
    .out_data_o (out_data_o)
  );

endmodule

// File: hdl/brlw_deque.sv
`timescale 1ns / 1ps
// Monotonic deque: circular value/position memory with head, tail and count.
// Front and back entries are read every cycle with write forwarding. Uses brlw_pkg.
module brlw_deque import brlw_pkg::*; #(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  dq_op_e                       op_i,
  input  logic signed [SAMPLE_W-1:0]   wr_val_i,
  input  logic [$clog2(DEPTH):0]       wr_pos_i,
  output logic                         empty_o,
  output logic signed [SAMPLE_W-1:0]   front_val_o,
  output logic [$clog2(DEPTH):0]       front_pos_o,
  output logic signed [SAMPLE_W-1:0]   back_val_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned PW = AW + 1;
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
  localparam logic [PW-1:0] FULL = PW'(DEPTH);

  logic signed [SAMPLE_W-1:0] val_mem [DEPTH];
  logic [PW-1:0]              pos_mem [DEPTH];

  logic [AW-1:0] head_q, head_d, tail_q, tail_d, back_addr;
  logic [PW-1:0] count_q, count_d;
  logic          we;

  logic signed [SAMPLE_W-1:0] front_val_q, back_val_q;
  logic [PW-1:0]              front_pos_q;

  function automatic logic [AW-1:0] idx_inc(input logic [AW-1:0] x);
    idx_inc = (x == LAST) ? '0 : x + AW'(1);
  endfunction

  function automatic logic [AW-1:0] idx_dec(input logic [AW-1:0] x);
    idx_dec = (x == '0) ? LAST : x - AW'(1);
  endfunction

  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    case (op_i)
      DQ_NONE: begin
      end
      DQ_CLEAR: begin
        head_d  = '0;
        tail_d  = '0;
        count_d = '0;
      end
      DQ_POP_FRONT: begin
        head_d  = idx_inc(head_q);
        count_d = count_q - PW'(1);
      end
      DQ_POP_BACK: begin
        tail_d  = idx_dec(tail_q);
        count_d = count_q - PW'(1);
      end
      DQ_PUSH: begin
        tail_d  = idx_inc(tail_q);
        count_d = count_q + PW'(1);
      end
      default: begin
      end
    endcase
  end

  assign we        = (op_i == DQ_PUSH);
  assign back_addr = idx_dec(tail_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

  // read-before-write memory, new data forwarded on address match
  always_ff @(posedge clk_i) begin
    if (we) begin
      val_mem[tail_q] <= wr_val_i;
      pos_mem[tail_q] <= wr_pos_i;
    end
    if (we && tail_q == head_d) begin
      front_val_q <= wr_val_i;
      front_pos_q <= wr_pos_i;
    end else begin
      front_val_q <= val_mem[head_d];
      front_pos_q <= pos_mem[head_d];
    end
    if (we && tail_q == back_addr) begin
      back_val_q <= wr_val_i;
    end else begin
      back_val_q <= val_mem[back_addr];
    end
  end

  assign empty_o     = (count_q == '0);
  assign front_val_o = front_val_q;
  assign front_pos_o = front_pos_q;
  assign back_val_o  = back_val_q;

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op_i == DQ_POP_FRONT || op_i == DQ_POP_BACK) |-> count_q != '0)
    else $error("deque pop while empty");

  a_no_overfill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op_i == DQ_PUSH) |=> count_q <= FULL)
    else $error("deque count above depth");

endmodule

// File: hdl/brlw_datapath.sv
`timescale 1ns / 1ps
// Datapath: range limit, window edges, best length, the max/min deques and the
// result register. Driven by brlw_ctrl commands. Uses brlw_pkg, brlw_deque.
module brlw_datapath import brlw_pkg::*; #(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  brlw_cmd_t            cmd_i,
  output brlw_stat_t           stat_o,
  input  brlw_in_t             in_data_i,
  input  logic                 cfg_we_i,
  input  logic [LIMIT_W-1:0]   cfg_data_i,
  output brlw_out_t            out_data_o
);

  localparam int unsigned PW = $clog2(DEPTH) + 1;
  localparam logic [PW-1:0] DEPTH_P = PW'(DEPTH);

  logic [LIMIT_W-1:0]         limit_q;
  logic signed [SAMPLE_W-1:0] sample_q;
  logic [PW-1:0]              ws_q, cur_q, best_q;
  logic                       capped_q;
  brlw_out_t                  out_q;

  dq_op_e                     mx_op, mn_op;
  logic                       mx_empty, mn_empty;
  logic signed [SAMPLE_W-1:0] mx_front_val, mn_front_val, mx_back_val, mn_back_val;
  logic [PW-1:0]              mx_front_pos, mn_front_pos;

  logic [PW-1:0]              cur_off, mx_off, mn_off, earliest, len, best_upd, best_new;
  logic                       mx_stale, mn_stale, mx_pop, mn_pop, over;
  logic signed [SAMPLE_W:0]   range_diff;

  brlw_deque #(.DEPTH(DEPTH)) u_max_dq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_i        (mx_op),
    .wr_val_i    (sample_q),
    .wr_pos_i    (cur_q),
    .empty_o     (mx_empty),
    .front_val_o (mx_front_val),
    .front_pos_o (mx_front_pos),
    .back_val_o  (mx_back_val)
  );

  brlw_deque #(.DEPTH(DEPTH)) u_min_dq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_i        (mn_op),
    .wr_val_i    (sample_q),
    .wr_pos_i    (cur_q),
    .empty_o     (mn_empty),
    .front_val_o (mn_front_val),
    .front_pos_o (mn_front_pos),
    .back_val_o  (mn_back_val)
  );

  assign cur_off  = cur_q - ws_q;
  assign mx_off   = mx_front_pos - ws_q;
  assign mn_off   = mn_front_pos - ws_q;
  assign mx_stale = !mx_empty && (mx_off >= DEPTH_P);
  assign mn_stale = !mn_empty && (mn_off >= DEPTH_P);
  assign mx_pop   = !mx_empty && (mx_back_val <= sample_q);
  assign mn_pop   = !mn_empty && (mn_back_val >= sample_q);

  assign range_diff = $signed({mx_front_val[SAMPLE_W-1], mx_front_val})
                    - $signed({mn_front_val[SAMPLE_W-1], mn_front_val});
  assign over = !mx_empty && !mn_empty && (range_diff > $signed({1'b0, limit_q}));

  assign earliest = (mx_off <= mn_off) ? mx_front_pos : mn_front_pos;

  assign len      = cur_off + PW'(1);
  assign best_upd = (len > best_q) ? len : best_q;
  assign best_new = (best_upd > DEPTH_P) ? DEPTH_P : best_upd;

  assign stat_o.cap_need   = (cur_off >= DEPTH_P);
  assign stat_o.trim_need  = mx_stale | mn_stale;
  assign stat_o.pop_need   = mx_pop | mn_pop;
  assign stat_o.over_limit = over;

  always_comb begin
    mx_op = DQ_NONE;
    mn_op = DQ_NONE;
    if (cmd_i.start && in_data_i.restart) begin
      mx_op = DQ_CLEAR;
      mn_op = DQ_CLEAR;
    end else if (cmd_i.trim || cmd_i.shrink) begin
      if (mx_stale) mx_op = DQ_POP_FRONT;
      if (mn_stale) mn_op = DQ_POP_FRONT;
    end else if (cmd_i.push) begin
      if (mx_pop || mn_pop) begin
        if (mx_pop) mx_op = DQ_POP_BACK;
        if (mn_pop) mn_op = DQ_POP_BACK;
      end else begin
        mx_op = DQ_PUSH;
        mn_op = DQ_PUSH;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= '0;
      ws_q    <= '0;
      cur_q   <= '0;
      best_q  <= '0;
    end else begin
      if (cfg_we_i) limit_q <= cfg_data_i;
      if (cmd_i.start && in_data_i.restart) begin
        ws_q   <= '0;
        cur_q  <= '0;
        best_q <= '0;
      end
      if (cmd_i.cap) ws_q <= cur_q - DEPTH_P + PW'(1);
      if (cmd_i.shrink && !(mx_stale || mn_stale) && over) ws_q <= earliest + PW'(1);
      if (cmd_i.finish) begin
        cur_q  <= cur_q + PW'(1);
        best_q <= best_new;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      sample_q <= in_data_i.sample;
      capped_q <= 1'b0;
    end
    if (cmd_i.cap) capped_q <= 1'b1;
    if (cmd_i.finish) begin
      out_q.window_length <= LEN_W'(len);
      out_q.best_length   <= LEN_W'(best_new);
      out_q.window_capped <= capped_q;
    end
  end

  assign out_data_o = out_q;

  a_len_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish |-> (len != '0) && (len <= DEPTH_P))
    else $error("window length out of range");

  a_room_on_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.push && !(mx_pop || mn_pop)) |-> (cur_off < DEPTH_P))
    else $error("push into a full window");

endmodule

// File: hdl/brlw_ctrl.sv
`timescale 1ns / 1ps
// Controller: sequences cap, trim, push and shrink phases for one item at a
// time and owns the result valid flag. Uses brlw_pkg.
module brlw_ctrl import brlw_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  brlw_stat_t stat_i,
  output brlw_cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CAP,
    S_TRIM,
    S_PUSH,
    S_SHRINK,
    S_DONE
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   out_free;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    cmd_o        = '0;
    cmd_o.start  = (state_q == S_IDLE) && in_valid_i;
    cmd_o.cap    = (state_q == S_CAP) && stat_i.cap_need;
    cmd_o.trim   = (state_q == S_TRIM);
    cmd_o.push   = (state_q == S_PUSH);
    cmd_o.shrink = (state_q == S_SHRINK);
    cmd_o.finish = (state_q == S_DONE) && out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.finish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) state_q <= S_CAP;
        end
        S_CAP: begin
          state_q <= stat_i.cap_need ? S_TRIM : S_PUSH;
        end
        S_TRIM: begin
          if (!stat_i.trim_need) state_q <= S_PUSH;
        end
        S_PUSH: begin
          if (!stat_i.pop_need) state_q <= S_SHRINK;
        end
        S_SHRINK: begin
          if (!stat_i.trim_need && !stat_i.over_limit) state_q <= S_DONE;
        end
        S_DONE: begin
          if (out_free) state_q <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// File: sim/bounded_range_longest_window_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for bounded_range_longest_window: predicts window and best lengths
// per item from its own deque tracker. Depends on brlw_pkg and the block's RTL.
module bounded_range_longest_window_tb;
  import brlw_pkg::*;

  localparam int unsigned DEPTH       = DEPTH_DEF;
  localparam int unsigned CYCLE_LIMIT = 600000;

  typedef struct {
    longint      value;
    int unsigned pos;
  } dq_entry_t;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  brlw_in_t            in_data   = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  brlw_out_t           out_data;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [LIMIT_W-1:0]  cfg_data  = '0;

  // window tracker state
  dq_entry_t           peak_q[$];
  dq_entry_t           trough_q[$];
  int unsigned         win_start = 0;
  int unsigned         cur_pos   = 0;
  int unsigned         best_len  = 0;
  logic [LIMIT_W-1:0]  range_lim = '0;

  brlw_in_t            feed[$];
  brlw_out_t           window_expect[$];
  logic [31:0]         walk_base = '0;
  logic [31:0]         limit_plan[9];

  int send_gap_pct   = 0;
  int recv_stall_pct = 0;
  int n_queued       = 0;
  int n_items        = 0;
  int n_results      = 0;
  int n_capped       = 0;
  int n_cfg          = 0;
  int mismatches     = 0;
  int best_seen      = 0;
  int cycles         = 0;

  bounded_range_longest_window #(
    .DEPTH(DEPTH)
  ) uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycles, window_expect.size());
      $display("simulation failed");
      $finish;
    end
  end

  function automatic void drop_stale(ref dq_entry_t q[$]);
    while (q.size() > 0 && (q[0].pos - win_start) >= DEPTH) void'(q.pop_front());
  endfunction

  task automatic track_window(input brlw_in_t it);
    longint      v;
    int unsigned a;
    int unsigned b;
    int unsigned len;
    logic        capped;
    dq_entry_t   e;
    brlw_out_t   res;
    v = longint'(it.sample);
    capped = 1'b0;
    if (it.restart) begin
      peak_q.delete();
      trough_q.delete();
      win_start = 0;
      cur_pos   = 0;
      best_len  = 0;
    end
    if ((cur_pos - win_start) >= DEPTH) begin
      win_start = cur_pos - DEPTH + 1;
      drop_stale(peak_q);
      drop_stale(trough_q);
      capped = 1'b1;
    end
    e.value = v;
    e.pos   = cur_pos;
    while (peak_q.size() > 0 && peak_q[$].value <= v) void'(peak_q.pop_back());
    if (peak_q.size() >= DEPTH) void'(peak_q.pop_front());
    peak_q.push_back(e);
    while (trough_q.size() > 0 && trough_q[$].value >= v) void'(trough_q.pop_back());
    if (trough_q.size() >= DEPTH) void'(trough_q.pop_front());
    trough_q.push_back(e);
    while (peak_q.size() > 0 && trough_q.size() > 0 &&
           (peak_q[0].value - trough_q[0].value) > longint'(range_lim)) begin
      a = peak_q[0].pos;
      b = trough_q[0].pos;
      win_start = (((a - win_start) <= (b - win_start)) ? a : b) + 1;
      drop_stale(peak_q);
      drop_stale(trough_q);
    end
    len = cur_pos - win_start + 1;
    if (len > best_len) best_len = len;
    if (best_len > DEPTH) best_len = DEPTH;
    cur_pos++;
    res.window_length = len[LEN_W-1:0];
    res.best_length   = best_len[LEN_W-1:0];
    res.window_capped = capped;
    window_expect.push_back(res);
  endtask

  // sender
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        track_window(in_data);
        n_items++;
      end
      if (!in_valid || in_ready) begin
        if (feed.size() > 0 && $urandom_range(99) >= send_gap_pct) begin
          in_data  <= feed.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver and checker
  always @(posedge clk) begin : watch_results
    brlw_out_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        n_results++;
        if (out_data.window_capped) n_capped++;
        if (int'(out_data.best_length) > best_seen) best_seen = int'(out_data.best_length);
        if (window_expect.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: result len %0d best %0d cap %0d with nothing expected", $time,
                     out_data.window_length, out_data.best_length, out_data.window_capped);
          mismatches++;
        end else begin
          want = window_expect.pop_front();
          if (out_data.window_length !== want.window_length ||
              out_data.best_length !== want.best_length ||
              out_data.window_capped !== want.window_capped) begin
            if (mismatches < 10)
              $display("%0t: result %0d expected len %0d best %0d cap %0d, got %0d %0d %0d",
                       $time, n_results, want.window_length, want.best_length,
                       want.window_capped, out_data.window_length, out_data.best_length,
                       out_data.window_capped);
            mismatches++;
          end
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic queue_item(input logic [31:0] sample, input logic restart);
    brlw_in_t x;
    x.sample  = sample;
    x.restart = restart;
    feed.push_back(x);
    n_queued++;
  endtask

  task automatic queue_random_item(input logic allow_restart);
    logic [31:0] s;
    case ($urandom_range(19))
      0: s = $urandom;
      1: begin
        case ($urandom_range(3))
          0: s = 32'h7FFF_FFFF;
          1: s = 32'h8000_0000;
          2: s = 32'h0000_0000;
          default: s = 32'hFFFF_FFFF;
        endcase
      end
      2: begin
        walk_base = $urandom;
        s = walk_base;
      end
      default: s = walk_base + $urandom_range(16) - 8;
    endcase
    queue_item(s, allow_restart && ($urandom_range(29) == 0));
  endtask

  task automatic drain();
    while (n_items != n_queued || window_expect.size() != 0) @(posedge clk);
  endtask

  task automatic write_limit(input logic [LIMIT_W-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    range_lim = value;
    n_cfg++;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    send_gap_pct   = 8;
    recv_stall_pct = 49;

    // limit still at its reset value of zero: only equal samples share a window
    queue_item(32'h0000_0000, 1'b1);
    queue_item(32'h0000_0000, 1'b0);
    queue_item(32'h7FFF_FFFF, 1'b0);
    queue_item(32'h7FFF_FFFF, 1'b0);
    queue_item(32'h8000_0000, 1'b0);
    queue_item(32'h8000_0000, 1'b1);
    queue_item(32'hFFFF_FFFF, 1'b0);
    queue_item(32'h0000_0001, 1'b0);
    drain();

    // widest limit: full signed span still fits
    write_limit(32'hFFFF_FFFF);
    queue_item(32'h7FFF_FFFF, 1'b1);
    queue_item(32'h8000_0000, 1'b0);
    queue_item(32'h0000_0000, 1'b0);
    queue_item(32'h7FFF_FFFF, 1'b0);
    drain();

    // one below: full span must shrink the window
    write_limit(32'hFFFF_FFFE);
    queue_item(32'h8000_0000, 1'b1);
    queue_item(32'h7FFF_FFFF, 1'b0);
    queue_item(32'h7FFF_FFFE, 1'b0);
    queue_item(32'h8000_0000, 1'b0);
    drain();

    write_limit(32'd5);
    queue_item(32'd10, 1'b1);
    queue_item(32'd12, 1'b0);
    queue_item(32'd15, 1'b0);
    queue_item(32'd16, 1'b0);
    queue_item(32'd11, 1'b0);
    queue_item(32'd14, 1'b0);
    queue_item(32'd9, 1'b0);
    queue_item(32'd20, 1'b0);
    drain();

    // long run without restart: window grows over hundreds of items
    write_limit(32'hFFFF_FFFF);
    queue_item($urandom, 1'b1);
    repeat (400) queue_random_item(1'b0);
    drain();

    limit_plan = '{32'd0, 32'd3, $urandom_range(64), 32'hFFFF_FFFF, $urandom_range(1000),
                   32'h8000_0000, $urandom, 32'd1, 32'h7FFF_FFFF};
    for (int m = 0; m < 3; m++) begin
      case (m)
        0: begin
          send_gap_pct   = 8;
          recv_stall_pct = 49;
        end
        1: begin
          send_gap_pct   = 49;
          recv_stall_pct = 8;
        end
        default: begin
          send_gap_pct   = 0;
          recv_stall_pct = 0;
        end
      endcase
      for (int s = 0; s < 3; s++) begin
        write_limit(limit_plan[m * 3 + s]);
        repeat (30) queue_random_item(1'b1);
        drain();
      end
    end

    repeat (20) @(posedge clk);
    $display("%0d items sent, %0d results checked, %0d capped, longest best length %0d",
             n_items, n_results, n_capped, best_seen);
    $display("%0d range limit writes over three pacing modes, %0d mismatches",
             n_cfg, mismatches);
    if (mismatches == 0 && window_expect.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
